// ----- src/sorted_key_set_table_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key set table
// Short forms for the clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_TABLE_MACROS_SVH
`define SORTED_KEY_SET_TABLE_MACROS_SVH

// Assertion on an explicit clock and reset.
`define SKST_ASSERT_ON(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error(msg);

// Assertion on the local clk and rst.
`define SKST_ASSERT(label, prop, msg) \
  `SKST_ASSERT_ON(label, clk, rst, prop, msg)

`endif

// ----- src/skst_pkg.sv -----
// ---------------------------------------------------------------------------
// Sorted key set table package
// Sizes, operation and status codes, and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package skst_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int ST_W     = 3;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_INS_KEY,
    S_DEL_RD,
    S_DEL_WR,
    S_RD_DATA,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ----- src/skst_if.sv -----
// ---------------------------------------------------------------------------
// Sorted key set table channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface skst_req_if;
  import skst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] key;
  logic [POS_W-1:0]        position;

  modport source (output valid, operation, key, position, input ready);
  modport sink   (input valid, operation, key, position, output ready);
endinterface

interface skst_rsp_if;
  import skst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [KEY_W-1:0] key_out;
  logic [POS_W-1:0]        position_out;
  logic [POS_W-1:0]        count;

  modport source (output valid, status, key_out, position_out, count, input ready);
  modport sink   (input valid, status, key_out, position_out, count, output ready);
endinterface

`default_nettype wire

// ----- src/skst_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module skst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/sorted_key_set_table.sv -----
// ---------------------------------------------------------------------------
// Sorted key set table
// Ascending set of signed keys without duplicates, held in a RAM and
// maintained by a small sequencer around one shared signed comparator.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  req      in   operation, key, position                  valid/ready
//  rsp      out  status, key_out, position_out, count      valid/ready
//
// One request is in work at a time; req.ready is high only when idle.
// Insert, delete and search scan each stored key below the lower bound with a
// read and a compare state, and insert and delete then move each higher key.
// A valid read passes through S_RD_DATA; clear, a bad read or an unused code go straight to S_RESP.
// Reset clears the count and the sequencer but not the key RAM.
// A stalled response holds the sequencer in its final state.
`default_nettype none

module sorted_key_set_table (
  input wire logic   clk,
  input wire logic   rst,
  skst_req_if.sink   req,
  skst_rsp_if.source rsp
);
  import skst_pkg::*;

  state_t state, state_next;

  logic [OP_W-1:0]         op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [POS_W-1:0]        pos_q;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        idx, idx_next;
  logic [CNT_W-1:0]        j, j_next;
  logic                    found, found_next;
  logic [ST_W-1:0]         res_status, res_status_next;
  logic signed [KEY_W-1:0] res_key, res_key_next;
  logic [POS_W-1:0]        res_pos, res_pos_next;

  logic                    out_valid, out_valid_next;
  logic                    out_load;
  logic [ST_W-1:0]         out_status;
  logic signed [KEY_W-1:0] out_key;
  logic [POS_W-1:0]        out_pos;
  logic [POS_W-1:0]        out_count;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [KEY_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [KEY_W-1:0]        ram_rdata;

  logic                    accept;
  logic                    key_less;
  logic                    key_equal;
  logic                    pos_ok;
  logic                    scan_more;
  logic                    ins_more;
  logic                    del_more;

  skst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // The shared comparator: stored key against the requested key.
  assign key_less  = $signed(ram_rdata) < key_q;
  assign key_equal = (ram_rdata == key_q);

  assign pos_ok    = (req.position != '0) &&
                     (CMP_W'(req.position) <= CMP_W'(count));
  assign scan_more = (idx < count);
  assign ins_more  = (j > idx);
  assign del_more  = (({1'b0, j} + 1'b1) < {1'b0, count});
  assign out_load  = (state == S_RESP) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.operation)
            OP_INSERT, OP_DELETE, OP_SEARCH: state_next = S_SCAN_RD;
            OP_READ:                         state_next = pos_ok ? S_RD_DATA : S_RESP;
            default:                         state_next = S_RESP;
          endcase
        end
      end
      S_SCAN_RD:  state_next = scan_more ? S_SCAN_CMP : S_DECIDE;
      S_SCAN_CMP: state_next = key_less ? S_SCAN_RD : S_DECIDE;
      S_DECIDE: begin
        case (op_q)
          OP_INSERT: state_next = (found || count == CNT_W'(CAPACITY)) ? S_RESP : S_INS_RD;
          OP_DELETE: state_next = found ? S_DEL_RD : S_RESP;
          default:   state_next = S_RESP;
        endcase
      end
      S_INS_RD:  state_next = ins_more ? S_INS_WR : S_INS_KEY;
      S_INS_WR:  state_next = S_INS_RD;
      S_INS_KEY: state_next = S_RESP;
      S_DEL_RD:  state_next = del_more ? S_DEL_WR : S_RESP;
      S_DEL_WR:  state_next = S_DEL_RD;
      S_RD_DATA: state_next = S_RESP;
      S_RESP:    state_next = out_load ? S_IDLE : S_RESP;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next      = count;
    idx_next        = idx;
    j_next          = j;
    found_next      = found;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_pos_next    = res_pos;
    ram_we          = 1'b0;
    ram_waddr       = IDX_W'(j);
    ram_wdata       = ram_rdata;
    ram_raddr       = IDX_W'(idx);
    out_valid_next  = out_valid;

    case (state)
      S_IDLE: begin
        ram_raddr       = IDX_W'(req.position - 1'b1);
        idx_next        = '0;
        res_status_next = ST_OK;
        res_key_next    = '0;
        res_pos_next    = '0;
        if (accept && req.operation == OP_READ && !pos_ok) begin
          res_status_next = ST_BADPOS;
        end
        if (accept && req.operation == OP_CLEAR) begin
          count_next = '0;
        end
      end
      S_SCAN_RD: begin
        if (!scan_more) begin
          found_next = 1'b0;
        end
      end
      S_SCAN_CMP: begin
        if (key_less) begin
          idx_next = idx + 1'b1;
        end else begin
          found_next = key_equal;
        end
      end
      S_DECIDE: begin
        res_key_next = key_q;
        res_pos_next = POS_W'({1'b0, idx} + 1'b1);
        j_next       = (op_q == OP_INSERT) ? count : idx;
        case (op_q)
          OP_INSERT: begin
            if (found) begin
              res_status_next = ST_DUP;
            end else if (count == CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end
          end
          OP_DELETE, OP_SEARCH: begin
            if (!found) begin
              res_status_next = ST_NOTFOUND;
            end
          end
          default: ;
        endcase
      end
      S_INS_RD: begin
        ram_raddr = IDX_W'(j - 1'b1);
      end
      S_INS_WR: begin
        ram_we = 1'b1;
        j_next = j - 1'b1;
      end
      S_INS_KEY: begin
        ram_we     = 1'b1;
        ram_waddr  = IDX_W'(idx);
        ram_wdata  = key_q;
        count_next = count + 1'b1;
      end
      S_DEL_RD: begin
        ram_raddr = IDX_W'(j + 1'b1);
        if (!del_more) begin
          count_next = count - 1'b1;
        end
      end
      S_DEL_WR: begin
        ram_we = 1'b1;
        j_next = j + 1'b1;
      end
      S_RD_DATA: begin
        res_key_next = ram_rdata;
        res_pos_next = pos_q;
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.operation;
      key_q <= req.key;
      pos_q <= req.position;
    end
    idx        <= idx_next;
    j          <= j_next;
    found      <= found_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_pos    <= res_pos_next;
    if (out_load) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_pos    <= res_pos;
      out_count  <= POS_W'(count);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.key_out      = out_key;
  assign rsp.position_out = out_pos;
  assign rsp.count        = out_count;

endmodule

`default_nettype wire

// ----- src/skst_checker.sv -----
// ---------------------------------------------------------------------------
// Sorted key set table checker
// Port-level properties of the request and response channels.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_set_table_macros.svh"

module skst_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              req_valid,
  input wire logic                              req_ready,
  input wire logic                              rsp_valid,
  input wire logic                              rsp_ready,
  input wire logic [skst_pkg::ST_W-1:0]         rsp_status,
  input wire logic signed [skst_pkg::KEY_W-1:0] rsp_key_out,
  input wire logic [skst_pkg::POS_W-1:0]        rsp_position_out,
  input wire logic [skst_pkg::POS_W-1:0]        rsp_count
);
  import skst_pkg::*;

  localparam logic [POS_W-1:0] FULL_COUNT = POS_W'(CAPACITY);

  // Only one request is in work at a time.
  `SKST_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "request taken while busy")

  `SKST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_key_out) && $stable(rsp_count), "stalled response changed")

  `SKST_ASSERT(a_badpos_zero, rsp_valid && rsp_status == ST_BADPOS |-> rsp_key_out == '0 && rsp_position_out == '0, "bad position result not zeroed")

  // A full table can only be reported with every slot taken.
  `SKST_ASSERT(a_full_count, rsp_valid && rsp_status == ST_FULL |-> rsp_count == FULL_COUNT, "table full reported below capacity")

endmodule

bind sorted_key_set_table skst_checker u_skst_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_key_out      (rsp.key_out),
  .rsp_position_out (rsp.position_out),
  .rsp_count        (rsp.count)
);

`default_nettype wire
